FILE: src/stgc_pkg.sv
// package: constants, types and helper functions of the glyph column generator
`timescale 1ns / 1ps
`default_nettype none

package stgc_pkg;

  // glyph store geometry
  localparam int GlyphWidth = 5;
  localparam int GlyphCount = 256;
  localparam int StoreDepth = GlyphCount * GlyphWidth;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ColW       = $clog2(GlyphWidth + 1);

  // field widths
  localparam int ByteW  = 8;
  localparam int WsW    = 4;
  localparam int HsW    = 4;
  localparam int SpW    = 5;
  localparam int SliceW = 3;
  localparam int RepW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 5;
  localparam int InDataW = 32;

  // scale limits
  localparam logic [WsW-1:0] WsMax = 4'd8;
  localparam logic [HsW-1:0] HsMax = 4'd8;
  localparam logic [SpW-1:0] SpMax = 5'd16;

  // mini font code window
  localparam logic [ByteW-1:0] MiniLow  = 8'h20;
  localparam logic [ByteW-1:0] MiniHigh = 8'h60;
  localparam logic [ByteW-1:0] GlyphBlank = 8'h00;

  // operation codes
  typedef enum logic {
    OpRender = 1'b0,
    OpWrite  = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgWidthScale  = 2'd0,
    CfgHeightScale = 2'd1,
    CfgSpacing     = 2'd2,
    CfgMiniFont    = 2'd3
  } cfg_idx_e;

  // control states
  typedef enum logic {
    StIdle = 1'b0,
    StEmit = 1'b1
  } state_e;

  typedef logic [SliceW-1:0] sel_row_t [ByteW];

  // source bit for output bit idx of slice sl: (8*sl+idx)/hs, hs already clamped
  // largest k below 8 with k*hs not above the bit position
  function automatic logic [SliceW-1:0] src_bit(input logic [HsW-1:0] hs,
                                                input logic [SliceW-1:0] sl,
                                                input logic [SliceW-1:0] idx);
    logic [5:0]        v;
    logic [6:0]        lim;
    logic [SliceW-1:0] q;
    v = {sl, idx};
    q = '0;
    for (int k = 1; k < 8; k++) begin
      lim = 7'(k) * {3'b000, hs};
      if ({1'b0, v} >= lim) begin
        q = SliceW'(k);
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

FILE: src/scaled_text_glyph_column_generator.sv
// An accepted render beat is loaded into the per item registers (StEmit); its column
// bytes then go to the output register, one byte per cycle unless the output stalls.
// No new item is accepted until the current item's last byte is loaded.
// The glyph store is read one column ahead through its registered read port.
// Reset clears control state and restores the configuration; the glyph store is
// undefined until written and has no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scaled_text_glyph_column_generator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [stgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [stgc_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // font_addr[10:0], font_data[18:11], char_code[26:19], slice_index[29:27], zero
  input  wire logic [stgc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // operation[0]
  input  wire logic                           s_axis_tuser_i,
  // line_end
  input  wire logic                           s_axis_tlast_i,
  // output stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // column_byte[7:0]
  output logic [stgc_pkg::ByteW-1:0]          m_axis_tdata_o,
  // line_last[0]
  output logic                                m_axis_tuser_o,
  // run_last
  output logic                                m_axis_tlast_o
);
  import stgc_pkg::*;

  // configuration registers
  logic [WsW-1:0] width_scale_q;
  logic [HsW-1:0] height_scale_q;
  logic [SpW-1:0] spacing_q;
  logic           mini_font_q;

  // per item registers
  state_e          state_q, state_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RepW-1:0] rep_q, rep_d;
  logic [SpW-1:0]  spc_q, spc_d;
  logic [WsW-1:0]  ws_q, ws_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic            blank_q, blank_d;
  logic            line_q, line_d;
  sel_row_t        sel_q, sel_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_line_q, out_line_d;

  // glyph store
  logic [ByteW-1:0] mem_q [StoreDepth];
  logic [ByteW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;

  // input fields
  logic [AddrW-1:0]  in_addr;
  logic [ByteW-1:0]  in_data;
  logic [ByteW-1:0]  in_code;
  logic [SliceW-1:0] in_slice;
  logic              in_op;
  logic              in_accept;

  // item decode
  logic [ByteW-1:0] glyph;
  logic [HsW-1:0]   hs_eff;
  logic [ByteW-1:0] scaled;
  logic             in_col;
  logic             rep_end;
  logic             is_last;
  logic             load_en;

  assign in_addr  = s_axis_tdata_i[AddrW-1:0];
  assign in_data  = s_axis_tdata_i[AddrW+ByteW-1:AddrW];
  assign in_code  = s_axis_tdata_i[AddrW+2*ByteW-1:AddrW+ByteW];
  assign in_slice = s_axis_tdata_i[AddrW+2*ByteW+SliceW-1:AddrW+2*ByteW];
  assign in_op    = s_axis_tuser_i;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_scale_q  <= 4'd1;
      height_scale_q <= 4'd1;
      spacing_q      <= 5'd1;
      mini_font_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWidthScale:  width_scale_q  <= cfg_data_i[WsW-1:0];
        CfgHeightScale: height_scale_q <= cfg_data_i[HsW-1:0];
        CfgSpacing:     spacing_q      <= cfg_data_i[SpW-1:0];
        CfgMiniFont:    mini_font_q    <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // glyph mapping and clamped scale values
  always_comb begin
    glyph = in_code;
    if (mini_font_q) begin
      if (in_code < MiniLow || in_code > MiniHigh) begin
        glyph = GlyphBlank;
      end else begin
        glyph = in_code - MiniLow;
      end
    end
    if (height_scale_q == '0) begin
      hs_eff = 4'd1;
    end else if (height_scale_q > HsMax) begin
      hs_eff = HsMax;
    end else begin
      hs_eff = height_scale_q;
    end
  end

  // vertical scaling of the column in the read register
  always_comb begin
    for (int b = 0; b < ByteW; b++) begin
      scaled[b] = rd_data_q[sel_q[b]];
    end
  end

  // step decode
  assign in_col  = (col_q < ColW'(GlyphWidth));
  assign rep_end = (rep_q == RepW'(ws_q - 4'd1));
  assign is_last = in_col ? ((col_q == ColW'(GlyphWidth - 1)) && rep_end && (sp_q == '0))
                          : (spc_q == sp_q - 5'd1);
  assign load_en = !out_valid_q || m_axis_tready_i;

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    col_d       = col_q;
    rep_d       = rep_q;
    spc_d       = spc_q;
    ws_d        = ws_q;
    sp_d        = sp_q;
    blank_d     = blank_q;
    line_d      = line_q;
    sel_d       = sel_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_line_d  = out_line_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (op_e'(in_op) == OpWrite) begin
            wr_en = (in_addr < AddrW'(StoreDepth));
          end else begin
            state_d = StEmit;
            base_d  = AddrW'(glyph) * AddrW'(GlyphWidth);
            col_d   = '0;
            rep_d   = '0;
            spc_d   = '0;
            if (width_scale_q == '0) begin
              ws_d = 4'd1;
            end else if (width_scale_q > WsMax) begin
              ws_d = WsMax;
            end else begin
              ws_d = width_scale_q;
            end
            sp_d    = (spacing_q > SpMax) ? SpMax : spacing_q;
            blank_d = ({1'b0, in_slice} >= hs_eff);
            line_d  = s_axis_tlast_i;
            for (int b = 0; b < ByteW; b++) begin
              sel_d[b] = src_bit(hs_eff, in_slice, SliceW'(b));
            end
          end
        end
      end
      StEmit: begin
        if (load_en) begin
          out_valid_d = 1'b1;
          out_byte_d  = (in_col && !blank_q) ? scaled : '0;
          out_last_d  = is_last;
          out_line_d  = is_last && line_q;
          if (is_last) begin
            state_d = StIdle;
          end
          if (in_col) begin
            if (rep_end) begin
              rep_d = '0;
              col_d = col_q + 1'b1;
            end else begin
              rep_d = rep_q + 1'b1;
            end
          end else begin
            spc_d = spc_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // read one column ahead of the byte being loaded
  assign rd_addr = base_d + AddrW'(col_d);

  // glyph store ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[in_addr] <= in_data;
    end
    if (rd_addr < AddrW'(StoreDepth)) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    col_q      <= col_d;
    rep_q      <= rep_d;
    spc_q      <= spc_d;
    ws_q       <= ws_d;
    sp_q       <= sp_d;
    blank_q    <= blank_d;
    line_q     <= line_d;
    sel_q      <= sel_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_line_q <= out_line_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_line_q;

  // the final byte of a character is in the output register once the run ends
  a_run_end_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && state_d == StIdle) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("run ended without a last beat");

  // a line flag only rides on the last beat of a character
  a_line_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("line_last without run_last");

  // column counter does not exceed GlyphWidth while emitting
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (col_q <= ColW'(GlyphWidth)))
    else $error("column counter out of range");

  // repeat counter stays below the width scale in the column phase
  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && in_col) |-> ({1'b0, rep_q} < ws_q))
    else $error("repeat counter out of range");

endmodule

`default_nettype wire
